[sv/nrta_pkg.sv]
`timescale 1ns / 1ps

package nrta_pkg;

  // Table geometry and field widths.
  localparam int REGIONS     = 1024;
  localparam int DEPTH_BITS  = 16;
  localparam int TIME_BITS   = 48;
  localparam int REGION_BITS = 10;
  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int IDX_BITS    = (REGIONS > 1) ? $clog2(REGIONS) : 1;

  // One table row holds the nesting depth above the accumulated time.
  localparam int ROW_BITS = DEPTH_BITS + TIME_BITS;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [TIME_BITS-1:0]  time_t;
  typedef logic [ROW_BITS-1:0]   row_t;

  localparam depth_t DEPTH_MAX = '1;
  localparam time_t  TIME_MAX  = '1;
  localparam idx_t   IDX_LAST  = idx_t'(REGIONS - 1);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ENTER = 2'd0,
    MODE_EXIT  = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK           = 2'd0,
    STAT_EXIT_IGNORED = 2'd1,
    STAT_DEPTH_SAT    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_WRITE
  } state_t;

endpackage

[sv/nrta_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module nrta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/nested_region_time_accumulator_core.sv]
`timescale 1ns / 1ps
// Each request passes through the read, update and write-back steps in turn;
// the single port pair of the region table takes no new request until
// write-back is done, and write-back waits while the output is stalled.
// Reset: after rst_n is released the depth and accumulated-time table is cleared,
// one region per cycle, for all 1024 regions, during which in_stall stays high.

module nested_region_time_accumulator_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [nrta_pkg::MODE_BITS-1:0]      in_mode,
  input  logic [nrta_pkg::REGION_BITS-1:0]    in_region_id,
  input  logic [nrta_pkg::TIME_BITS-1:0]      in_timestamp,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [nrta_pkg::REGION_BITS-1:0]    out_region_echo,
  output logic [nrta_pkg::TIME_BITS-1:0]      out_total_time,
  output logic [nrta_pkg::DEPTH_BITS-1:0]     out_nesting_level,
  output logic [nrta_pkg::STATUS_BITS-1:0]    out_status
);

  import nrta_pkg::*;

  // Control state.
  state_t state_r, state_nxt;
  idx_t   clr_r, clr_nxt;
  logic   out_valid_r, out_valid_nxt;

  // The request being worked on, captured when it is accepted.
  mode_t                  mode_r;
  logic [REGION_BITS-1:0] region_r;
  time_t                  time_r;
  idx_t                   idx_r;

  // Results of the update step, held for the write-back step.
  depth_t  depth_upd_r, depth_upd_nxt;
  time_t   acc_old_r;
  time_t   elapsed_r, elapsed_nxt;
  logic    add_r, add_nxt;
  logic    wr_start_r, wr_start_nxt;
  status_t status_r, status_nxt;

  // Output register.
  logic [REGION_BITS-1:0] out_region_r;
  time_t                  out_total_r;
  depth_t                 out_depth_r;
  status_t                out_status_r;

  // Table ports.
  logic  row_we, row_re, start_we;
  idx_t  row_waddr, rd_addr;
  row_t  row_wdata, row_rdata;
  time_t start_rdata;

  logic  accept;
  logic  out_load;
  logic  out_free;
  depth_t depth_rd;
  time_t  acc_rd;
  logic [TIME_BITS:0] acc_sum;
  time_t  acc_new;

  // The row memory keeps nesting depth and accumulated time side by side, so
  // one read and one write cover both. Start times live in a second memory
  // that is never cleared: an entry is only read after an enter wrote it.
  nrta_ram #(.WIDTH(ROW_BITS), .DEPTH(REGIONS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (rd_addr),
    .rdata (row_rdata)
  );

  nrta_ram #(.WIDTH(TIME_BITS), .DEPTH(REGIONS)) u_start_ram (
    .clk   (clk),
    .we    (start_we),
    .waddr (idx_r),
    .wdata (time_r),
    .re    (row_re),
    .raddr (rd_addr),
    .rdata (start_rdata)
  );

  // The output register can take a new result when it is empty or its
  // current result is leaving at this edge.
  assign out_free = !out_valid_r || !out_stall;

  // Region indices wrap onto the table size; the echo keeps the raw value.
  assign rd_addr = idx_t'(in_region_id);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == IDX_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Output and control decode of the state machine.
  always_comb begin
    in_stall  = 1'b1;
    row_re    = 1'b0;
    row_we    = 1'b0;
    start_we  = 1'b0;
    row_waddr = idx_r;
    row_wdata = {depth_upd_r, acc_new};
    out_load  = 1'b0;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        // Clearing pass: zero depth and accumulated time, one row per cycle.
        row_we    = 1'b1;
        row_waddr = clr_r;
        row_wdata = '0;
        clr_nxt   = clr_r + idx_t'(1);
      end
      S_IDLE: begin
        in_stall = 1'b0;
        row_re   = in_valid;
      end
      S_READ: begin
        in_stall = 1'b1;
      end
      S_WRITE: begin
        // Write back and publish the result in the same cycle, so the table
        // and the result never disagree.
        row_we   = out_free;
        start_we = out_free && wr_start_r;
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign accept = in_valid && !in_stall;

  // Update step: decide the new depth, the status and whether the elapsed
  // time is added, from the row that the memory has just returned.
  assign depth_rd = row_rdata[ROW_BITS-1:TIME_BITS];
  assign acc_rd   = row_rdata[TIME_BITS-1:0];

  always_comb begin
    depth_upd_nxt = depth_rd;
    add_nxt       = 1'b0;
    wr_start_nxt  = 1'b0;
    status_nxt    = STAT_OK;
    // Elapsed time wraps like the free-running timestamp counter.
    elapsed_nxt   = time_r - start_rdata;
    case (mode_r)
      MODE_ENTER: begin
        // Only the outermost enter starts the clock for a region.
        wr_start_nxt = (depth_rd == '0);
        if (depth_rd == DEPTH_MAX) begin
          status_nxt = STAT_DEPTH_SAT;
        end else begin
          depth_upd_nxt = depth_rd + depth_t'(1);
        end
      end
      MODE_EXIT: begin
        if (depth_rd == '0) begin
          status_nxt = STAT_EXIT_IGNORED;
        end else begin
          depth_upd_nxt = depth_rd - depth_t'(1);
          // Leaving the outermost level closes the timed interval.
          add_nxt = (depth_rd == depth_t'(1));
        end
      end
      default: begin
        // A read, or the unused code, leaves the row untouched.
      end
    endcase
  end

  // Write-back step: saturating add of the elapsed time.
  assign acc_sum = {1'b0, acc_old_r} + {1'b0, elapsed_r};
  assign acc_new = !add_r ? acc_old_r :
                   acc_sum[TIME_BITS] ? TIME_MAX : acc_sum[TIME_BITS-1:0];

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode_t'(in_mode);
      region_r <= in_region_id;
      time_r   <= in_timestamp;
      idx_r    <= rd_addr;
    end
    if (state_r == S_READ) begin
      depth_upd_r <= depth_upd_nxt;
      acc_old_r   <= acc_rd;
      elapsed_r   <= elapsed_nxt;
      add_r       <= add_nxt;
      wr_start_r  <= wr_start_nxt;
      status_r    <= status_nxt;
    end
    if (out_load) begin
      out_region_r <= region_r;
      out_total_r  <= acc_new;
      out_depth_r  <= depth_upd_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_region_echo   = out_region_r;
  assign out_total_time    = out_total_r;
  assign out_nesting_level = out_depth_r;
  assign out_status        = out_status_r;

endmodule
